FILE: rtl/core/packed_2bpp_framebuffer_macros.svh
// assertion macros for the packed 2bpp framebuffer
// no dependencies; included by the modules that carry assertions
`ifndef PACKED_2BPP_FRAMEBUFFER_MACROS_SVH
`define PACKED_2BPP_FRAMEBUFFER_MACROS_SVH
`ifndef SYNTHESIS
`define P2BFB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("p2bfb assertion failed");
`define P2BFB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("p2bfb assertion failed");
`else
`define P2BFB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define P2BFB_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/core/p2bfb_pkg.sv
// shared types and constants for the packed 2bpp framebuffer
// no dependencies
package p2bfb_pkg;

    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 240;
    localparam int PIX_PER_WORD  = 16;
    localparam int WORDS_PER_ROW = (SCREEN_WIDTH + PIX_PER_WORD - 1) / PIX_PER_WORD;
    localparam int STORE_WORDS   = WORDS_PER_ROW * SCREEN_HEIGHT;
    localparam int ADDR_W        = $clog2(STORE_WORDS);
    localparam int PLOT_W        = 8 + $clog2(WORDS_PER_ROW + 1) + 1;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int PAL_ENTRIES   = 4;

    localparam logic [1:0] CMD_PLOT  = 2'd0;
    localparam logic [1:0] CMD_SCAN  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [15:0] PAL_RESET_ZERO  = 16'h0000;
    localparam logic [15:0] PAL_RESET_ONE   = 16'h07E0;
    localparam logic [15:0] PAL_RESET_TWO   = 16'hF81F;
    localparam logic [15:0] PAL_RESET_THREE = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_PLOT  = 2'd0,
        OP_SCAN  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op_kind;

    typedef struct packed {
        t_op_kind           kind;
        logic [ADDR_W-1:0]  addr;
        logic [3:0]         slot;
        logic [1:0]         code;
        logic               hit;
    } t_op;

endpackage

FILE: rtl/core/p2bfb_front.sv
// front end: takes input transfers, decodes and range-checks them
// into queued operations; depends on p2bfb_pkg
module p2bfb_front (
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [31:0]     s_axis_tdata,   // cmd, pos_x, pos_y, pixel_code, word_index
    input  logic            i_queue_full,
    input  logic            i_init_done,
    output logic            o_push,
    output p2bfb_pkg::t_op  o_op
);
    import p2bfb_pkg::*;

    logic [1:0]        w_cmd;
    logic [7:0]        w_pos_x;
    logic [7:0]        w_pos_y;
    logic [1:0]        w_code;
    logic [11:0]       w_widx;
    logic [PLOT_W-1:0] w_plot_word;
    logic              w_plot_hit;
    logic              w_widx_hit;
    logic              w_accept;

    assign w_cmd   = s_axis_tdata[1:0];
    assign w_pos_x = s_axis_tdata[9:2];
    assign w_pos_y = s_axis_tdata[17:10];
    assign w_code  = s_axis_tdata[19:18];
    assign w_widx  = s_axis_tdata[31:20];

    assign w_plot_word = PLOT_W'(w_pos_y) * PLOT_W'(WORDS_PER_ROW) + PLOT_W'(w_pos_x[7:4]);
    assign w_plot_hit  = ({1'b0, w_pos_x} < 9'(SCREEN_WIDTH))
                      && ({1'b0, w_pos_y} < 9'(SCREEN_HEIGHT))
                      && (w_plot_word < PLOT_W'(STORE_WORDS));
    assign w_widx_hit  = ({1'b0, w_widx} < 13'(STORE_WORDS));

    assign s_axis_tready = !i_queue_full && i_init_done;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        o_push    = 1'b0;
        o_op.kind = OP_PLOT;
        o_op.addr = w_plot_word[ADDR_W-1:0];
        o_op.slot = w_pos_x[3:0];
        o_op.code = w_code;
        o_op.hit  = w_plot_hit;
        unique case (w_cmd)
            CMD_PLOT: begin
                o_push = w_accept && w_plot_hit;
            end
            CMD_SCAN: begin
                o_op.kind = OP_SCAN;
                o_op.addr = w_widx[ADDR_W-1:0];
                o_op.hit  = w_widx_hit;
                o_push    = w_accept;
            end
            CMD_CLEAR: begin
                o_op.kind = OP_CLEAR;
                o_op.addr = w_widx[ADDR_W-1:0];
                o_op.hit  = w_widx_hit;
                o_push    = w_accept && w_widx_hit;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/core/p2bfb_queue.sv
// short operation queue between front and back
// depends on p2bfb_pkg
module p2bfb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  p2bfb_pkg::t_op  i_op,
    input  logic            i_pop,
    output p2bfb_pkg::t_op  o_op,
    output logic            o_empty,
    output logic            o_full
);
    import p2bfb_pkg::*;

    t_op               r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W:0]   n_count;
    logic              w_push;
    logic              w_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_op    = r_slots[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slots[r_wr_ptr] <= i_op;
        end
    end

endmodule

FILE: rtl/core/p2bfb_back.sv
// back end: pixel store, clearing pass, plot/clear/scan execution and palette
// depends on p2bfb_pkg and packed_2bpp_framebuffer_macros.svh
`include "packed_2bpp_framebuffer_macros.svh"
module p2bfb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [15:0]     i_cfg_data,
    input  logic            i_q_empty,
    input  p2bfb_pkg::t_op  i_q_op,
    output logic            o_q_pop,
    output logic            o_init_done,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [15:0]     m_axis_tdata,   // pixel_colour
    output logic            m_axis_tlast
);
    import p2bfb_pkg::*;

    typedef enum logic [4:0] {
        S_INIT     = 5'b00001,
        S_IDLE     = 5'b00010,
        S_PLOT_RD  = 5'b00100,
        S_SCAN_RD  = 5'b01000,
        S_SCAN_OUT = 5'b10000
    } t_state;

    logic [31:0]       r_mem [STORE_WORDS];
    logic [31:0]       r_rd_data;

    t_state            r_state,     n_state;
    logic [ADDR_W-1:0] r_init_addr, n_init_addr;
    t_op               r_op,        n_op;
    logic [31:0]       r_word,      n_word;
    logic [3:0]        r_cnt,       n_cnt;
    logic              r_out_valid, n_out_valid;
    logic [15:0]       r_out_data,  n_out_data;
    logic              r_out_last,  n_out_last;
    logic [15:0]       r_pal [PAL_ENTRIES];

    logic              w_mem_we;
    logic [ADDR_W-1:0] w_mem_waddr;
    logic [31:0]       w_mem_wdata;
    logic              w_mem_re;
    logic [ADDR_W-1:0] w_mem_raddr;
    logic [4:0]        w_shift;
    logic              w_out_load;

    assign w_shift     = {r_op.slot, 1'b0};
    assign w_out_load  = (r_state == S_SCAN_OUT) && (!r_out_valid || m_axis_tready);
    assign o_init_done = (r_state != S_INIT);

    always_comb begin
        n_state     = r_state;
        n_init_addr = r_init_addr;
        n_op        = r_op;
        n_word      = r_word;
        n_cnt       = r_cnt;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_valid = (r_out_valid && !m_axis_tready);
        o_q_pop     = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_waddr = i_q_op.addr;
        w_mem_wdata = '0;
        w_mem_re    = 1'b0;
        w_mem_raddr = i_q_op.addr;
        unique case (r_state)
            S_INIT: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_init_addr;
                n_init_addr = r_init_addr + 1'b1;
                if (r_init_addr == ADDR_W'(STORE_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_op    = i_q_op;
                    unique case (i_q_op.kind)
                        OP_PLOT: begin
                            w_mem_re = 1'b1;
                            n_state  = S_PLOT_RD;
                        end
                        OP_SCAN: begin
                            w_mem_re = i_q_op.hit;
                            n_state  = S_SCAN_RD;
                        end
                        OP_CLEAR: begin
                            w_mem_we = i_q_op.hit;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_PLOT_RD: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_op.addr;
                w_mem_wdata = (r_rd_data & ~(32'd3 << w_shift))
                            | (32'(r_op.code) << w_shift);
                n_state     = S_IDLE;
            end
            S_SCAN_RD: begin
                n_word  = r_op.hit ? r_rd_data : '0;
                n_cnt   = '0;
                n_state = S_SCAN_OUT;
            end
            S_SCAN_OUT: begin
                if (w_out_load) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_pal[r_word[1:0]];
                    n_out_last  = (r_cnt == 4'(PIX_PER_WORD - 1));
                    n_word      = r_word >> 2;
                    n_cnt       = r_cnt + 1'b1;
                    if (r_cnt == 4'(PIX_PER_WORD - 1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_addr <= '0;
            r_out_valid <= 1'b0;
            r_pal[0]    <= PAL_RESET_ZERO;
            r_pal[1]    <= PAL_RESET_ONE;
            r_pal[2]    <= PAL_RESET_TWO;
            r_pal[3]    <= PAL_RESET_THREE;
        end else begin
            r_state     <= n_state;
            r_init_addr <= n_init_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_pal[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_word     <= n_word;
        r_cnt      <= n_cnt;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    // pixel store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[w_mem_raddr];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    `P2BFB_ASSERT_IMP(a_no_out_in_init, i_clk, i_rst_n, (r_state == S_INIT), !r_out_valid)
    `P2BFB_ASSERT_NXT(a_plot_one_write, i_clk, i_rst_n, (r_state == S_PLOT_RD), (r_state == S_IDLE))
    `P2BFB_ASSERT_NXT(a_last_on_sixteenth, i_clk, i_rst_n, (w_out_load && (r_cnt == 4'(PIX_PER_WORD - 1))), (r_out_valid && r_out_last && (r_state == S_IDLE)))
    `P2BFB_ASSERT_IMP(a_no_pop_when_busy, i_clk, i_rst_n, (r_state != S_IDLE), !o_q_pop)

endmodule

FILE: rtl/core/packed_2bpp_framebuffer.sv
// scan path: a popped scan reads its word from the store into r_rd_data, copies it to r_word
// in S_SCAN_RD and sends its pixels through the output register in S_SCAN_OUT
// throughput: the input takes one transfer a cycle while the 4-deep op queue has room;
// the back end: a clear writes as it is popped, a plot does a read-modify-write on the store port,
// and a scan reads its word and sends 16 pixels, one pixel a cycle when the output is not stalled
// reset: palette to defaults, then a clearing pass over every store word with input held off
// top level: front end, op queue and back end; depends on p2bfb_pkg
module packed_2bpp_framebuffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // cmd, pos_x, pos_y, pixel_code, word_index
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // pixel_colour
    output logic        m_axis_tlast    // last_of_word
);
    import p2bfb_pkg::*;

    logic w_push;
    t_op  w_push_op;
    t_op  w_head_op;
    logic w_pop;
    logic w_empty;
    logic w_full;
    logic w_init_done;

    p2bfb_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_queue_full  (w_full),
        .i_init_done   (w_init_done),
        .o_push        (w_push),
        .o_op          (w_push_op)
    );

    p2bfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .i_pop   (w_pop),
        .o_op    (w_head_op),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    p2bfb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_q_empty     (w_empty),
        .i_q_op        (w_head_op),
        .o_q_pop       (w_pop),
        .o_init_done   (w_init_done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: verif/tb.sv
// self-checking testbench for packed_2bpp_framebuffer: plot, clear and scan transfers
// are predicted against a private framebuffer copy and palette; depends on p2bfb_pkg
`timescale 1ns / 1ps
module tb;
    import p2bfb_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 300000;
    localparam int         DRAIN_WAIT  = 40;
    localparam int         HOLD_CYCLES = 400;
    localparam int         PHASE_ITEMS = 150;

    typedef struct {
        logic [15:0] colour;
        logic        last;
    } t_pixel_exp;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [1:0]  code;
        logic [11:0] widx;
        bit          lit;
        logic [15:0] lit_colour;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    logic [31:0] fb_words [0:STORE_WORDS-1];
    logic [15:0] pal_tab [0:PAL_ENTRIES-1];
    t_pixel_exp  pending_pixels [$];
    t_dir_row    dir_rows [$];
    int          hot_words [$];
    int          send_idle = 35;
    int          recv_idle = 71;
    int          phase_no = 1;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          errors = 0;
    int          cycle_cnt = 0;

    packed_2bpp_framebuffer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [31:0] pack_item(input logic [1:0] cmd, input logic [7:0] x,
                                              input logic [7:0] y, input logic [1:0] code,
                                              input logic [11:0] widx);
        return {widx, code, y, x, cmd};
    endfunction

    function automatic t_dir_row mk_row(input logic [1:0] cmd, input logic [7:0] x,
                                        input logic [7:0] y, input logic [1:0] code,
                                        input logic [11:0] widx, input bit lit,
                                        input logic [15:0] lit_colour);
        t_dir_row r;
        r.cmd = cmd;
        r.x = x;
        r.y = y;
        r.code = code;
        r.widx = widx;
        r.lit = lit;
        r.lit_colour = lit_colour;
        return r;
    endfunction

    function automatic void apply_to_framebuffer(input logic [31:0] d);
        logic [1:0]  cmd;
        logic [7:0]  px;
        logic [7:0]  py;
        logic [1:0]  code;
        logic [11:0] widx;
        logic [31:0] word;
        int          w;
        t_pixel_exp  e;
        cmd = d[1:0];
        px = d[9:2];
        py = d[17:10];
        code = d[19:18];
        widx = d[31:20];
        case (cmd)
            CMD_PLOT: begin
                if (px < SCREEN_WIDTH && py < SCREEN_HEIGHT) begin
                    w = int'(py) * WORDS_PER_ROW + int'(px) / PIX_PER_WORD;
                    if (w < STORE_WORDS)
                        fb_words[w][2 * (int'(px) % PIX_PER_WORD) +: 2] = code;
                end
            end
            CMD_CLEAR: begin
                if (widx < STORE_WORDS)
                    fb_words[widx] = '0;
            end
            CMD_SCAN: begin
                word = (widx < STORE_WORDS) ? fb_words[widx] : '0;
                for (int k = 0; k < PIX_PER_WORD; k++) begin
                    e.colour = pal_tab[word[2 * k +: 2]];
                    e.last = (k == PIX_PER_WORD - 1);
                    pending_pixels.push_back(e);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] rand_item();
        int          r;
        int          x;
        int          y;
        int          w;
        logic [31:0] d;
        r = $urandom_range(99);
        d = $urandom();
        if (r < 55) begin
            x = $urandom_range(SCREEN_WIDTH - 1);
            case ($urandom_range(2))
                0: y = $urandom_range(5);
                1: y = SCREEN_HEIGHT - 1 - $urandom_range(3);
                default: y = $urandom_range(SCREEN_HEIGHT - 1);
            endcase
            w = y * WORDS_PER_ROW + x / PIX_PER_WORD;
            hot_words.push_back(w);
            if (hot_words.size() > 16)
                void'(hot_words.pop_front());
            d = pack_item(CMD_PLOT, x[7:0], y[7:0], d[19:18], d[31:20]);
        end else if (r < 80) begin
            if (hot_words.size() != 0)
                w = hot_words[$urandom_range(hot_words.size() - 1)];
            else
                w = $urandom_range(STORE_WORDS - 1);
            d = pack_item(CMD_SCAN, d[9:2], d[17:10], d[19:18], w[11:0]);
        end else if (r < 88) begin
            if (hot_words.size() != 0 && $urandom_range(1))
                w = hot_words[$urandom_range(hot_words.size() - 1)];
            else
                w = $urandom_range(STORE_WORDS - 1);
            d = pack_item(CMD_CLEAR, d[9:2], d[17:10], d[19:18], w[11:0]);
        end else if (r < 91) begin
            d = pack_item(CMD_PLOT, 8'($urandom_range(255, SCREEN_WIDTH)), d[17:10],
                          d[19:18], d[31:20]);
        end else if (r < 94) begin
            w = $urandom_range(4095, STORE_WORDS);
            d = pack_item($urandom_range(1) ? CMD_SCAN : CMD_CLEAR, d[9:2], d[17:10],
                          d[19:18], w[11:0]);
        end else if (r < 97) begin
            d[1:0] = CMD_UNUSED;
        end
        return d;
    endfunction

    task automatic send_item(input logic [31:0] data, input bit lit,
                             input logic [15:0] lit_colour);
        t_pixel_exp e;
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        if (lit) begin
            for (int k = 0; k < PIX_PER_WORD; k++) begin
                e.colour = lit_colour;
                e.last = (k == PIX_PER_WORD - 1);
                pending_pixels.push_back(e);
            end
        end else begin
            apply_to_framebuffer(data);
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic program_palette(input logic [15:0] c0, input logic [15:0] c1,
                                   input logic [15:0] c2, input logic [15:0] c3);
        logic [15:0] vals [0:PAL_ENTRIES-1];
        vals[0] = c0;
        vals[1] = c1;
        vals[2] = c2;
        vals[3] = c3;
        for (int i = 0; i < PAL_ENTRIES; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= i[1:0];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            pal_tab[i] = vals[i];
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        errors++;
    endtask

    task automatic check_pixel(input logic [15:0] colour, input logic last);
        t_pixel_exp e;
        if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel %h last %b", colour, last));
        end else begin
            e = pending_pixels.pop_front();
            if (colour !== e.colour)
                report_mismatch($sformatf("colour %h, expected %h", colour, e.colour));
            if (last !== e.last)
                report_mismatch($sformatf("last %b, expected %b", last, e.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                check_pixel(m_axis_tdata, m_axis_tlast);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (phase_no == 3 && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < STORE_WORDS; i++)
            fb_words[i] = '0;
        pal_tab[0] = PAL_RESET_ZERO;
        pal_tab[1] = PAL_RESET_ONE;
        pal_tab[2] = PAL_RESET_TWO;
        pal_tab[3] = PAL_RESET_THREE;

        // after reset every word reads black, out-of-range scans too
        dir_rows.push_back(mk_row(CMD_SCAN, 8'd0, 8'd0, 2'd0, 12'd0, 1, PAL_RESET_ZERO));
        dir_rows.push_back(mk_row(CMD_SCAN, 8'd0, 8'd0, 2'd0, 12'd3599, 1, PAL_RESET_ZERO));
        dir_rows.push_back(mk_row(CMD_SCAN, 8'd0, 8'd0, 2'd0, 12'd3600, 1, PAL_RESET_ZERO));
        dir_rows.push_back(mk_row(CMD_SCAN, 8'd255, 8'd255, 2'd3, 12'd4095, 1,
                                  PAL_RESET_ZERO));
        dir_rows.push_back(mk_row(CMD_PLOT, 8'd0, 8'd0, 2'd1, 12'd0, 0, '0));
        dir_rows.push_back(mk_row(CMD_PLOT, 8'd15, 8'd0, 2'd2, 12'd4095, 0, '0));
        dir_rows.push_back(mk_row(CMD_PLOT, 8'd239, 8'd239, 2'd3, 12'd0, 0, '0));
        // off-screen plots, then in-range plots, scans, an unused command and clears
        dir_rows.push_back(mk_row(CMD_PLOT, 8'd240, 8'd0, 2'd3, 12'd0, 0, '0));
        dir_rows.push_back(mk_row(CMD_PLOT, 8'd0, 8'd240, 2'd3, 12'd0, 0, '0));
        dir_rows.push_back(mk_row(CMD_PLOT, 8'd255, 8'd255, 2'd3, 12'd4095, 0, '0));
        dir_rows.push_back(mk_row(CMD_SCAN, 8'd0, 8'd0, 2'd0, 12'd0, 0, '0));
        dir_rows.push_back(mk_row(CMD_SCAN, 8'd0, 8'd0, 2'd0, 12'd3599, 0, '0));
        dir_rows.push_back(mk_row(CMD_PLOT, 8'd239, 8'd0, 2'd1, 12'd0, 0, '0));
        dir_rows.push_back(mk_row(CMD_SCAN, 8'd0, 8'd0, 2'd0, 12'd14, 0, '0));
        dir_rows.push_back(mk_row(CMD_PLOT, 8'd16, 8'd0, 2'd3, 12'd0, 0, '0));
        dir_rows.push_back(mk_row(CMD_PLOT, 8'd16, 8'd0, 2'd0, 12'd0, 0, '0));
        dir_rows.push_back(mk_row(CMD_PLOT, 8'd31, 8'd0, 2'd2, 12'd0, 0, '0));
        dir_rows.push_back(mk_row(CMD_SCAN, 8'd0, 8'd0, 2'd0, 12'd1, 0, '0));
        dir_rows.push_back(mk_row(CMD_UNUSED, 8'd255, 8'd255, 2'd3, 12'd4095, 0, '0));
        dir_rows.push_back(mk_row(CMD_CLEAR, 8'd0, 8'd0, 2'd0, 12'd0, 0, '0));
        dir_rows.push_back(mk_row(CMD_SCAN, 8'd0, 8'd0, 2'd0, 12'd0, 1, PAL_RESET_ZERO));
        dir_rows.push_back(mk_row(CMD_CLEAR, 8'd0, 8'd0, 2'd0, 12'd3600, 0, '0));
        dir_rows.push_back(mk_row(CMD_CLEAR, 8'd255, 8'd255, 2'd3, 12'd4095, 0, '0));
        dir_rows.push_back(mk_row(CMD_SCAN, 8'd0, 8'd0, 2'd0, 12'd3599, 0, '0));
        dir_rows.push_back(mk_row(CMD_CLEAR, 8'd0, 8'd0, 2'd0, 12'd3599, 0, '0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(pack_item(dir_rows[i].cmd, dir_rows[i].x, dir_rows[i].y,
                                dir_rows[i].code, dir_rows[i].widx),
                      dir_rows[i].lit, dir_rows[i].lit_colour);
        settle();

        program_palette(16'hFFFF, 16'h0000, 16'h8001, 16'h7FFE);
        repeat (PHASE_ITEMS) send_item(rand_item(), 0, '0);
        settle();

        send_idle = 71;
        recv_idle = 35;
        phase_no = 2;
        program_palette(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
        repeat (PHASE_ITEMS) send_item(rand_item(), 0, '0);
        settle();

        send_idle = 0;
        recv_idle = 0;
        program_palette(16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00);
        phase_no = 3;
        repeat (PHASE_ITEMS + 10) send_item(rand_item(), 0, '0);
        settle();

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
